// ===== rtl/k_way_sorted_merge_macros.svh =====
// Assertion macros for the k-way merge block.
// Included by the top level; depends on nothing else.
`ifndef K_WAY_SORTED_MERGE_MACROS_SVH
`define K_WAY_SORTED_MERGE_MACROS_SVH
// check an implication on every clock edge outside reset
`define KWM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// check an implication in the cycle after the antecedent
`define KWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/kwm_pkg.sv =====
// Shared types and constants for the k-way merge block.
// No dependencies.
package kwm_pkg;
   localparam int MaxRows = 16;
   localparam int RowW = $clog2(MaxRows);
   localparam int SizeW = $clog2(MaxRows + 1);
   localparam int AddrW = 2 * RowW;

   typedef struct packed {
      logic [31:0] value;
      logic [RowW-1:0] row;
      logic [RowW-1:0] col;
   } heap_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BUILD_RD, ST_BUILD_PUSH, ST_SIFT_UP, ST_POP,
      ST_SIFT_DN, ST_NEXT_RD, ST_NEXT_PUSH, ST_SIFT_UP2, ST_EMIT
   } state_type;

   typedef struct packed {
      logic store_wr;
      logic rd_build;
      logic rd_next;
      logic push;
      logic up_step;
      logic pop;
      logic dn_step;
      logic clear;
      logic load_out;
      logic out_empty;
   } cmd_type;

   typedef struct packed {
      logic up_done;
      logic dn_done;
      logic heap_empty;
      logic build_done;
      logic has_next;
   } status_type;

   function automatic logic item_less(heap_item_type a, heap_item_type b);
      if (a.value != b.value) return $signed(a.value) < $signed(b.value);
      return a.row < b.row;
   endfunction
endpackage

// ===== rtl/kwm_datapath.sv =====
// Datapath: element memory, heap registers and sift index.
// Depends on kwm_pkg.
module kwm_datapath (
   input  logic clock,
   input  kwm_pkg::cmd_type cmd,
   output kwm_pkg::status_type status,
   input  logic [kwm_pkg::RowW-1:0] wr_row,
   input  logic [kwm_pkg::RowW-1:0] wr_col,
   input  logic [31:0] wr_value,
   input  logic [kwm_pkg::SizeW-1:0] k_eff,
   output logic [31:0] out_value,
   output logic out_last
);
   import kwm_pkg::*;

   logic [31:0] mem [MaxRows*MaxRows];
   logic [31:0] rd_ff;
   heap_item_type heap_ff [MaxRows];
   logic [SizeW-1:0] size_ff;
   logic [RowW-1:0] idx_ff;
   logic [SizeW-1:0] bld_ff;
   heap_item_type top_ff;
   logic [RowW-1:0] prow_ff, pcol_ff;
   logic [31:0] out_value_ff;
   logic out_last_ff;

   logic [RowW-1:0] par;
   logic [SizeW:0] lch, rch;
   logic [RowW-1:0] mi;
   logic lsel, rsel, up_swap;

   always_comb begin
      par = (idx_ff - 1'b1) >> 1;
      lch = {1'b0, idx_ff, 1'b1};
      rch = lch + 1'b1;
      up_swap = (idx_ff != '0) && item_less(heap_ff[idx_ff], heap_ff[par]);
      lsel = (lch < (SizeW+1)'(size_ff))
         && item_less(heap_ff[lch[RowW-1:0]], heap_ff[idx_ff]);
      mi = lsel ? lch[RowW-1:0] : idx_ff;
      rsel = (rch < (SizeW+1)'(size_ff))
         && item_less(heap_ff[rch[RowW-1:0]], heap_ff[mi]);
      if (rsel) mi = rch[RowW-1:0];
      status.up_done = !up_swap;
      status.dn_done = (mi == idx_ff);
      status.heap_empty = (size_ff == '0);
      status.build_done = (bld_ff >= k_eff);
      status.has_next = ((SizeW+1)'(top_ff.col) + 1'b1) < (SizeW+1)'(k_eff);
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr) mem[{wr_row, wr_col}] <= wr_value;
      if (cmd.rd_build) begin
         rd_ff <= mem[{bld_ff[RowW-1:0], {RowW{1'b0}}}];
         prow_ff <= bld_ff[RowW-1:0];
         pcol_ff <= '0;
      end
      if (cmd.rd_next) begin
         rd_ff <= mem[{top_ff.row, top_ff.col + 1'b1}];
         prow_ff <= top_ff.row;
         pcol_ff <= top_ff.col + 1'b1;
      end
      if (cmd.clear) begin
         size_ff <= '0;
         bld_ff <= '0;
      end
      if (cmd.push) begin
         heap_ff[size_ff[RowW-1:0]] <= '{value: rd_ff, row: prow_ff, col: pcol_ff};
         idx_ff <= size_ff[RowW-1:0];
         size_ff <= size_ff + 1'b1;
         if (cmd.rd_build == 1'b0) bld_ff <= bld_ff + 1'b1;
      end
      if (cmd.up_step && up_swap) begin
         heap_ff[idx_ff] <= heap_ff[par];
         heap_ff[par] <= heap_ff[idx_ff];
         idx_ff <= par;
      end
      if (cmd.pop) begin
         top_ff <= heap_ff[0];
         heap_ff[0] <= heap_ff[size_ff[RowW-1:0] - 1'b1];
         size_ff <= size_ff - 1'b1;
         idx_ff <= '0;
      end
      if (cmd.dn_step && mi != idx_ff) begin
         heap_ff[idx_ff] <= heap_ff[mi];
         heap_ff[mi] <= heap_ff[idx_ff];
         idx_ff <= mi;
      end
      if (cmd.load_out) begin
         out_value_ff <= cmd.out_empty ? 32'd0 : top_ff.value;
         out_last_ff <= !cmd.out_empty && (size_ff == '0);
      end
   end

   assign out_value = out_value_ff;
   assign out_last = out_last_ff;
endmodule

// ===== rtl/kwm_control.sv =====
// Controller state machine for the k-way merge.
// Depends on kwm_pkg.
module kwm_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic restart,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_is_empty,
   output kwm_pkg::cmd_type cmd,
   input  kwm_pkg::status_type status,
   output logic busy
);
   import kwm_pkg::*;

   state_type state_ff, state_in;
   logic started_ff, started_in;
   logic valid_ff, valid_in;
   logic empty_ff, empty_in;
   logic rsp_empty_ff, rsp_empty_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         started_ff <= 1'b0;
         valid_ff <= 1'b0;
         empty_ff <= 1'b0;
         rsp_empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
         valid_ff <= valid_in;
         empty_ff <= empty_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      started_in = started_ff;
      valid_in = valid_ff && rsp_stall;
      empty_in = empty_ff;
      rsp_empty_in = rsp_empty_ff;
      cmd = '0;
      req_stall = 1'b1;
      if (restart) started_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (!req_action) begin
                  cmd.store_wr = 1'b1;
                  started_in = 1'b0;
               end else if (!started_ff) begin
                  cmd.clear = 1'b1;
                  started_in = 1'b1;
                  state_in = ST_BUILD_RD;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_BUILD_RD: begin
            if (status.build_done) state_in = ST_POP;
            else begin
               cmd.rd_build = 1'b1;
               state_in = ST_BUILD_PUSH;
            end
         end
         ST_BUILD_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_SIFT_UP;
         end
         ST_SIFT_UP: begin
            cmd.up_step = 1'b1;
            if (status.up_done) state_in = ST_BUILD_RD;
         end
         ST_POP: begin
            if (status.heap_empty) begin
               state_in = ST_EMIT;
               empty_in = 1'b1;
            end else begin
               cmd.pop = 1'b1;
               empty_in = 1'b0;
               state_in = ST_SIFT_DN;
            end
         end
         ST_SIFT_DN: begin
            cmd.dn_step = 1'b1;
            if (status.dn_done) state_in = status.has_next ? ST_NEXT_RD : ST_EMIT;
         end
         ST_NEXT_RD: begin
            cmd.rd_next = 1'b1;
            state_in = ST_NEXT_PUSH;
         end
         ST_NEXT_PUSH: begin
            cmd.push = 1'b1;
            cmd.rd_build = 1'b0;
            state_in = ST_SIFT_UP2;
         end
         ST_SIFT_UP2: begin
            cmd.up_step = 1'b1;
            if (status.up_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!valid_in) begin
               cmd.load_out = 1'b1;
               cmd.out_empty = empty_ff;
               rsp_empty_in = empty_ff;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign busy = (state_ff != ST_IDLE);
endmodule

// ===== rtl/k_way_sorted_merge.sv =====
// k-way merge of a 16x16 sorted matrix through a min-heap.
// A load writes one element. A pop sifts the heap down d levels and, if the popped
// row has a next element, sifts that element up u levels (one level per cycle, each
// up to log2 K) before its result is registered. The first pop after a restart or
// after a load also builds the heap.
// Synchronous active-high reset clears control; row_count resets to 16.
module k_way_sorted_merge (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_action,
   input  logic [3:0] req_row_index,
   input  logic [3:0] req_col_index,
   input  logic signed [31:0] req_element_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_merged_value,
   output logic rsp_is_last,
   output logic rsp_is_empty,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_row_count
);
   import kwm_pkg::*;
`include "k_way_sorted_merge_macros.svh"

   cmd_type cmd;
   status_type status;
   logic busy;
   logic [4:0] rc_ff;
   logic [SizeW-1:0] k_eff;
   logic csr_wr;
   logic [31:0] mv;

   // keep register writes apart from input transactions
   assign csr_ready = !busy && !req_valid;
   assign csr_wr = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) rc_ff <= 5'd16;
      else if (csr_wr) rc_ff <= csr_row_count;
   end

   always_comb begin
      if (rc_ff == '0) k_eff = SizeW'(1);
      else if (rc_ff > 5'(MaxRows)) k_eff = SizeW'(MaxRows);
      else k_eff = SizeW'(rc_ff);
   end

   kwm_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_action,
      .restart(csr_wr), .rsp_valid, .rsp_stall, .rsp_is_empty,
      .cmd, .status, .busy
   );

   kwm_datapath u_dp (
      .clock, .cmd, .status,
      .wr_row(req_row_index), .wr_col(req_col_index),
      .wr_value(req_element_value), .k_eff,
      .out_value(mv), .out_last(rsp_is_last)
   );

   assign rsp_merged_value = mv;

   `KWM_ASSERT_IMPL(a_stall_busy, clock, reset, busy, req_stall, "input taken while busy")
   `KWM_ASSERT_IMPL(a_flags, clock, reset, rsp_valid, !(rsp_is_last && rsp_is_empty), "last and empty")
   `KWM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
endmodule
